// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while reset is held.
`define CHK_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is held.
`define CHK_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wdr_pkg.sv =====
package wdr_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FIELD_BITS = 96;
	localparam int DATA_BITS  = 192;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_DIV_ZERO = 1'b1;

	localparam logic ROUND_TRUNCATE = 1'b0;
	localparam logic ROUND_HALF_UP  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic rnd_cmp;
		logic rnd_inc;
		logic out_load;
	} wdr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic den_zero;
		logic round_en;
	} wdr_sts_t;

endpackage

// ===== sv/wdr_ctrl.sv =====
module wdr_ctrl import wdr_pkg::*; #(
	parameter int MANTISSA_BITS = 96
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  wdr_sts_t sts,
	output wdr_cmd_t cmd
);

	localparam int CNT_W = $clog2(MANTISSA_BITS);

	typedef enum logic [2:0] {
		IDLE,
		DIVIDE,
		RND_CMP,
		RND_INC,
		FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               m_tvalid_q;
	logic               out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == IDLE) && s_tvalid;
		cmd.step     = (state_q == DIVIDE) && !sts.den_zero;
		cmd.rnd_cmp  = (state_q == RND_CMP);
		cmd.rnd_inc  = (state_q == RND_INC);
		cmd.out_load = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// A new result may replace one that is taken at the same edge.
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						cnt_q   <= CNT_W'(MANTISSA_BITS - 1);
						state_q <= DIVIDE;
					end
				end
				DIVIDE: begin
					if (sts.den_zero) begin
						state_q <= FINISH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == '0) begin
							state_q <= sts.round_en ? RND_CMP : FINISH;
						end
					end
				end
				RND_CMP: begin
					state_q <= RND_INC;
				end
				RND_INC: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/wdr_dp.sv =====
module wdr_dp import wdr_pkg::*; #(
	parameter int MANTISSA_BITS = 96
) (
	input  logic                 clk,
	input  logic [DATA_BITS-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic [DATA_BITS-1:0] m_tdata,
	output logic                 m_tuser,
	input  wdr_cmd_t             cmd,
	output wdr_sts_t             sts
);

	localparam int M     = MANTISSA_BITS;
	localparam int EXT_W = (M > FIELD_BITS) ? M : FIELD_BITS;

	logic [M-1:0]           num_q;
	logic [M-1:0]           den_q;
	logic [M-1:0]           rem_q;
	logic [M-1:0]           quo_q;
	logic                   mode_q;
	logic                   ge_q;
	logic [DATA_BITS-1:0]   m_tdata_q;
	logic                   m_tuser_q;

	logic [EXT_W-1:0]       num_ext;
	logic [EXT_W-1:0]       den_ext;
	logic [M:0]             trial;
	logic [M+1:0]           diff;
	logic                   fits;
	logic [EXT_W-1:0]       quo_ext;
	logic [EXT_W-1:0]       rem_ext;

	// Operands narrower than the mantissa are zero-extended; wider ones lose their top bits.
	assign num_ext = EXT_W'(s_tdata[FIELD_BITS-1:0]);
	assign den_ext = EXT_W'(s_tdata[DATA_BITS-1:FIELD_BITS]);

	// One restoring step: bring down the next dividend bit and subtract if the divisor fits.
	assign trial = {rem_q, num_q[M-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = !diff[M+1];

	assign quo_ext = EXT_W'(quo_q);
	assign rem_ext = EXT_W'(rem_q);

	assign sts.den_zero = (den_q == '0);
	assign sts.round_en = (mode_q == ROUND_HALF_UP);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= num_ext[M-1:0];
			den_q  <= den_ext[M-1:0];
			rem_q  <= '0;
			quo_q  <= '0;
			mode_q <= s_tuser;
		end
		if (cmd.step) begin
			num_q <= {num_q[M-2:0], 1'b0};
			rem_q <= fits ? diff[M-1:0] : trial[M-1:0];
			quo_q <= {quo_q[M-2:0], fits};
		end
		if (cmd.rnd_cmp) begin
			ge_q <= ({rem_q, 1'b0} >= {1'b0, den_q});
		end
		if (cmd.rnd_inc && ge_q) begin
			quo_q <= quo_q + 1'b1;
		end
		if (cmd.out_load) begin
			if (sts.den_zero) begin
				m_tdata_q <= '0;
				m_tuser_q <= STATUS_DIV_ZERO;
			end else begin
				m_tdata_q <= {rem_ext[FIELD_BITS-1:0], quo_ext[FIELD_BITS-1:0]};
				m_tuser_q <= STATUS_OK;
			end
		end
	end

	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// ===== sv/wide_divider_with_rounding_core.sv =====
// Channel  | Direction | Ports                              | Contents
// ---------+-----------+------------------------------------+---------------------------------
// operands | in        | s_tvalid s_tready s_tdata s_tuser  | dividend, divisor, rounding mode
// results  | out       | m_tvalid m_tready m_tdata m_tuser  | quotient, remainder, status
//
// A rounded item passes through acceptance, one quotient bit per cycle in the shared subtractor,
// a rounding compare, an increment, and the move of the result into the output register. A
// truncated item skips the compare and the increment. A zero divisor is spotted in the first
// divide cycle and goes straight to the move into the output register.
// Only one item is in flight; a new one is taken while the previous result still waits, and a
// finished item holds until the output register is free.
// The asynchronous reset empties the controller and drops m_tvalid; no clearing pass is needed.
module wide_divider_with_rounding_core import wdr_pkg::*; #(
	parameter int MANTISSA_BITS = 96
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// dividend_low, dividend_mid, dividend_high, divisor_low, divisor_mid, divisor_high
	input  logic [DATA_BITS-1:0] s_tdata,
	// round_mode
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// quotient_low, quotient_mid, quotient_high, remainder_low, remainder_mid, remainder_high
	output logic [DATA_BITS-1:0] m_tdata,
	// status
	output logic                 m_tuser
);

	// The controller sequences the transaction; the datapath holds the operands, the
	// partial remainder, the quotient shift register and the output register.
	wdr_cmd_t cmd;
	wdr_sts_t sts;

	wdr_ctrl #(
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wdr_dp #(
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_dp (
		.clk     (clk),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

// ===== sv/wdr_checker.sv =====
`include "assert_macros.svh"

module wdr_checker import wdr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [DATA_BITS-1:0] s_tdata,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [DATA_BITS-1:0] m_tdata,
	input logic                 m_tuser
);

	// A stalled result stays offered.
	`CHK_CLK(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`CHK_CLK(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// A divide by zero reports zero quotient and remainder.
	`CHK_CLK(a_zero_div, m_tvalid && (m_tuser == STATUS_DIV_ZERO) |-> m_tdata == '0, "divide by zero result not cleared")

	// The divider is busy after taking an operand pair.
	`CHK_CLK(a_busy, s_tvalid && s_tready |=> !s_tready ##1 !s_tready, "operands taken while dividing")

	// Nothing is offered once reset has been seen at a clock edge.
	`CHK_CLK_ALWAYS(a_reset_idle, !arst_n |=> !m_tvalid, "result offered in reset")

endmodule

bind wide_divider_with_rounding_core wdr_checker u_wdr_checker (.*);

// ===== tb/sv/wide_divider_with_rounding_core_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the 96-bit divider with truncation or round-half-up.
// Operand transactions are queued by the stimulus block, driven by a clocked driver and
// predicted at the moment they are accepted. A clocked monitor takes every result
// transaction and compares it field by field with the oldest prediction still waiting.
module wide_divider_with_rounding_core_tb;
	import wdr_pkg::*;

	localparam int RANDOM_ITEMS  = 1550;
	// Cycles without any accepted transaction before the run is declared hung. The limit is
	// many times the slowest correct gap between handshakes.
	localparam int STALL_LIMIT   = 3000;
	// Quiet time after the last expected result, a little more than one full division.
	localparam int SETTLE_CYCLES = 150;
	// Window, counted in transactions, in which neither side idles.
	localparam int CALM_FROM     = 600;
	localparam int CALM_TO       = 900;
	localparam int IDLE_PERCENT  = 17;

	localparam logic [FIELD_BITS-1:0] ALL_ONES = {FIELD_BITS{1'b1}};
	localparam logic [FIELD_BITS-1:0] TOP_BIT  = {1'b1, {(FIELD_BITS-1){1'b0}}};
	localparam logic [FIELD_BITS-1:0] ODD_BITS = {(FIELD_BITS/2){2'b01}};
	localparam logic [FIELD_BITS-1:0] EVEN_BITS = {(FIELD_BITS/2){2'b10}};

	// One operand transaction. hold_for_drain makes the driver wait until every result
	// already owed by the block has come back before it offers this one.
	typedef struct {
		logic [FIELD_BITS-1:0] dividend;
		logic [FIELD_BITS-1:0] divisor;
		logic                  round_mode;
		bit                    hold_for_drain;
	} division_request_t;

	typedef struct {
		logic [FIELD_BITS-1:0] quotient;
		logic [FIELD_BITS-1:0] remainder;
		logic                  status;
	} division_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// dividend_low, dividend_mid, dividend_high, divisor_low, divisor_mid, divisor_high
	logic [DATA_BITS-1:0] s_tdata = '0;
	// round_mode
	logic                 s_tuser = ROUND_TRUNCATE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// quotient_low, quotient_mid, quotient_high, remainder_low, remainder_mid, remainder_high
	logic [DATA_BITS-1:0] m_tdata;
	// status
	logic                 m_tuser;

	division_request_t pending_divisions[$];
	division_result_t  owed_results[$];
	division_request_t on_bus;

	int unsigned total_requests = 0;
	int unsigned requests_taken = 0;
	int unsigned results_taken  = 0;
	int unsigned mismatches     = 0;
	int unsigned quiet_cycles   = 0;

	wide_divider_with_rounding_core #(
		.MANTISSA_BITS(FIELD_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expected outcome of one division. The rounding test doubles the remainder one bit
	// wider than the operands so that it cannot overflow, and it applies whether or not the
	// dividend is below the divisor. The increment wraps within the field width, which a
	// valid pair of operands can never actually reach.
	function automatic division_result_t divide_and_round(division_request_t req);
		division_result_t  res;
		logic [FIELD_BITS:0] twice_rem;
		res.quotient  = '0;
		res.remainder = '0;
		res.status    = STATUS_OK;
		if (req.divisor == '0) begin
			res.status = STATUS_DIV_ZERO;
		end else begin
			res.quotient  = req.dividend / req.divisor;
			res.remainder = req.dividend % req.divisor;
			twice_rem     = {res.remainder, 1'b0};
			if (req.round_mode == ROUND_HALF_UP && twice_rem >= {1'b0, req.divisor}) begin
				res.quotient = res.quotient + 1'b1;
			end
		end
		return res;
	endfunction

	// Random value confined to its lowest nbits bits (0 to the full width).
	function automatic logic [FIELD_BITS-1:0] random_operand(int unsigned nbits);
		logic [FIELD_BITS-1:0] v;
		v = {$urandom, $urandom, $urandom};
		return v & ((FIELD_BITS'(1) << nbits) - FIELD_BITS'(1));
	endfunction

	task automatic queue_division(logic [FIELD_BITS-1:0] dividend,
			logic [FIELD_BITS-1:0] divisor, logic round_mode, bit hold_for_drain);
		division_request_t req;
		req.dividend       = dividend;
		req.divisor        = divisor;
		req.round_mode     = round_mode;
		req.hold_for_drain = hold_for_drain;
		pending_divisions.push_back(req);
		total_requests++;
	endtask

	task automatic flag_mismatch(string field, logic [FIELD_BITS-1:0] want,
			logic [FIELD_BITS-1:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("result %0d: %s expected %h, got %h", results_taken, field, want, got);
		end
	endtask

	// Driver. A new transaction is offered only once the previous one has been taken, so
	// tvalid and the operands hold steady while a transaction waits. Each accepted transaction is predicted here,
	// from the very operands that were on the bus at the accepting edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= ROUND_TRUNCATE;
		end else begin
			if (s_tvalid && s_tready) begin
				owed_results.push_back(divide_and_round(on_bus));
				requests_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_divisions.size() != 0
						&& !(pending_divisions[0].hold_for_drain && owed_results.size() != 0)
						&& !((requests_taken < CALM_FROM || requests_taken >= CALM_TO)
							&& $urandom_range(0, 99) < IDLE_PERCENT)) begin
					on_bus = pending_divisions.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {on_bus.divisor, on_bus.dividend};
					s_tuser  <= on_bus.round_mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Back-pressure is random outside the calm window; each accepted result is
	// checked against the oldest outstanding prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_taken++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d arrived with nothing expected: %h status %b",
							results_taken, m_tdata, m_tuser);
					end
				end else begin
					division_result_t want;
					want = owed_results.pop_front();
					if (m_tdata[FIELD_BITS-1:0] !== want.quotient) begin
						flag_mismatch("quotient", want.quotient, m_tdata[FIELD_BITS-1:0]);
					end
					if (m_tdata[DATA_BITS-1:FIELD_BITS] !== want.remainder) begin
						flag_mismatch("remainder", want.remainder,
							m_tdata[DATA_BITS-1:FIELD_BITS]);
					end
					if (m_tuser !== want.status) begin
						flag_mismatch("status", FIELD_BITS'(want.status), FIELD_BITS'(m_tuser));
					end
				end
			end
			m_tready <= !((results_taken < CALM_FROM || results_taken >= CALM_TO)
				&& $urandom_range(0, 99) < IDLE_PERCENT);
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("wide_divider_with_rounding_core_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		logic [FIELD_BITS-1:0] divisor;
		logic [FIELD_BITS-1:0] multiplier;
		int unsigned           divisor_bits;

		// Directed cases. A zero divisor must zero both results whatever the dividend.
		queue_division('0, '0, ROUND_TRUNCATE, 1'b0);
		queue_division(ALL_ONES, '0, ROUND_HALF_UP, 1'b0);
		queue_division(FIELD_BITS'(5), '0, ROUND_HALF_UP, 1'b0);
		// Zero dividend, unit divisor and the largest quotient.
		queue_division('0, FIELD_BITS'(1), ROUND_HALF_UP, 1'b0);
		queue_division('0, ALL_ONES, ROUND_HALF_UP, 1'b0);
		queue_division(ALL_ONES, FIELD_BITS'(1), ROUND_TRUNCATE, 1'b0);
		queue_division(ALL_ONES, FIELD_BITS'(1), ROUND_HALF_UP, 1'b0);
		queue_division(ALL_ONES, ALL_ONES, ROUND_HALF_UP, 1'b0);
		// Dividend just below the divisor: rounding must still lift the quotient to one.
		queue_division(ALL_ONES - 1'b1, ALL_ONES, ROUND_TRUNCATE, 1'b0);
		queue_division(ALL_ONES - 1'b1, ALL_ONES, ROUND_HALF_UP, 1'b0);
		// A remainder just below a top-bit divisor, and a top-bit dividend.
		queue_division(ALL_ONES, TOP_BIT, ROUND_HALF_UP, 1'b0);
		queue_division(TOP_BIT, FIELD_BITS'(3), ROUND_HALF_UP, 1'b1);
		// Exact half and above half round up, just under half does not.
		queue_division(FIELD_BITS'(5), FIELD_BITS'(2), ROUND_TRUNCATE, 1'b0);
		queue_division(FIELD_BITS'(5), FIELD_BITS'(2), ROUND_HALF_UP, 1'b0);
		queue_division(FIELD_BITS'(2), FIELD_BITS'(5), ROUND_HALF_UP, 1'b0);
		queue_division(FIELD_BITS'(3), FIELD_BITS'(5), ROUND_HALF_UP, 1'b0);
		queue_division(FIELD_BITS'(1), FIELD_BITS'(2), ROUND_HALF_UP, 1'b0);
		queue_division(FIELD_BITS'(1), FIELD_BITS'(3), ROUND_HALF_UP, 1'b0);
		// Alternating bit patterns and a divisor whose only set bit is the lowest bit of the top word.
		queue_division(ODD_BITS, EVEN_BITS, ROUND_HALF_UP, 1'b0);
		queue_division(EVEN_BITS, ODD_BITS, ROUND_TRUNCATE, 1'b0);
		queue_division(ALL_ONES, FIELD_BITS'(1) << 64, ROUND_HALF_UP, 1'b0);

		// Random part. Operand lengths vary so that quotients of every size occur, and some
		// shapes aim straight at the rounding boundary.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			divisor_bits = $urandom_range(1, FIELD_BITS - 1);
			divisor      = random_operand(divisor_bits);
			divisor[divisor_bits-1] = 1'b1;
			multiplier   = random_operand($urandom_range(0, FIELD_BITS - 1 - divisor_bits));
			case ($urandom_range(0, 9))
				0: begin
					queue_division(random_operand(FIELD_BITS), random_operand(FIELD_BITS),
						1'($urandom_range(0, 1)), n % 200 == 199);
				end
				5: begin
					queue_division(random_operand($urandom_range(0, FIELD_BITS)), '0,
						1'($urandom_range(0, 1)), n % 200 == 199);
				end
				6: begin
					// Exact multiple: zero remainder, rounding must change nothing.
					queue_division(multiplier * divisor, divisor, 1'($urandom_range(0, 1)),
						n % 200 == 199);
				end
				7: begin
					// Remainder of half the divisor or one above it.
					queue_division(multiplier * divisor + (divisor >> 1)
						+ FIELD_BITS'($urandom_range(0, 1)), divisor,
						1'($urandom_range(0, 1)), n % 200 == 199);
				end
				8: begin
					// Dividend below the divisor.
					queue_division(divisor - random_operand($urandom_range(0, divisor_bits))
						% divisor - 1'b1, divisor, 1'($urandom_range(0, 1)),
						n % 200 == 199);
				end
				9: begin
					queue_division(random_operand(FIELD_BITS),
						FIELD_BITS'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
						n % 200 == 199);
				end
				default: begin
					queue_division(random_operand($urandom_range(0, FIELD_BITS)),
						random_operand($urandom_range(0, FIELD_BITS)),
						1'($urandom_range(0, 1)), n % 200 == 199);
				end
			endcase
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every transaction has been taken and answered, then allow a full
		// division's worth of time for any stray result to show up.
		while (requests_taken != total_requests || owed_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("wide_divider_with_rounding_core_tb: clean");
		end else begin
			$display("wide_divider_with_rounding_core_tb: errors");
		end
		$finish;
	end

endmodule
